FILE: src/adpcm_pkg.sv
// ----------------------------------------------------------------------------
// adpcm_pkg
// Shared types and constants for the DSP ADPCM frame decoder.
// ----------------------------------------------------------------------------
package adpcm_pkg;

    localparam int COEF_SETS     = 8;
    localparam int SEL_W         = 3;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int NIBBLES_W     = 56;
    localparam int COUNT_W       = 4;
    localparam int SHIFT_W       = 4;
    localparam int SAMPLE_W      = 16;
    localparam int PROD_W        = 32;
    localparam int FRAC_BITS     = 11;
    localparam int ACC_W         = 34;
    localparam int S_TDATA_W     = 72;

    localparam logic [COUNT_W-1:0] FRAME_SAMPLES = 4'd14;
    localparam logic [COUNT_W-1:0] COUNT_NONE    = 4'd0;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 34'sd1024;
    localparam logic signed [ACC_W-1:0] ACC_MAX    = 34'sd32767;
    localparam logic signed [ACC_W-1:0] ACC_MIN    = -34'sd32768;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX  = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_ZERO = 16'sh0000;

    // One frame as handed from the front to the sample engine.
    typedef struct packed {
        logic                        restart;
        logic [COUNT_W-1:0]          count;
        logic [SHIFT_W-1:0]          shift;
        logic signed [SAMPLE_W-1:0]  c1;
        logic signed [SAMPLE_W-1:0]  c2;
        logic [NIBBLES_W-1:0]        nibbles;
    } frame_cmd_t;

endpackage

FILE: src/adpcm_front.sv
// ----------------------------------------------------------------------------
// adpcm_front
// Accepts frame words, holds the predictor coefficient registers and turns
// each frame into a command for the sample engine.
// ----------------------------------------------------------------------------
module adpcm_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [adpcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [adpcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // frame input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: frame_header[7:0], frame_nibbles[63:8], emit_count[67:64], zero pad
    input  logic [adpcm_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: restart
    input  logic                               s_tuser,
    // command queue side
    output logic                               cmd_valid,
    input  logic                               cmd_ready,
    output adpcm_pkg::frame_cmd_t              cmd
);
    import adpcm_pkg::*;

    logic [CFG_DATA_W-1:0] coef_reg [COEF_SETS];

    logic [7:0]            header;
    logic [NIBBLES_W-1:0]  nibbles;
    logic [COUNT_W-1:0]    count_in;
    logic [SEL_W-1:0]      sel;
    logic [CFG_DATA_W-1:0] pair;
    logic                  cfg_hit;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = (cfg_index[CFG_INDEX_W-1:SEL_W] == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COEF_SETS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready && cfg_hit) begin
            coef_reg[cfg_index[SEL_W-1:0]] <= cfg_data;
        end
    end

    assign header   = s_tdata[7:0];
    assign nibbles  = s_tdata[63:8];
    assign count_in = s_tdata[67:64];
    // Header bit 7 is ignored; only bits 6:4 pick the predictor set.
    assign sel      = header[6:4];
    assign pair     = coef_reg[sel];

    always_comb begin
        cmd.restart = s_tuser;
        cmd.count   = (count_in > FRAME_SAMPLES) ? FRAME_SAMPLES : count_in;
        cmd.shift   = header[SHIFT_W-1:0];
        cmd.c1      = $signed(pair[31:16]);
        cmd.c2      = $signed(pair[15:0]);
        cmd.nibbles = nibbles;
    end

    assign cmd_valid = s_tvalid;
    assign s_tready  = cmd_ready;

`ifndef SYNTHESIS
    a_count_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid |-> (cmd.count <= FRAME_SAMPLES))
        else $error("frame command carries more samples than a frame holds");
`endif

endmodule

FILE: src/adpcm_queue.sv
// ----------------------------------------------------------------------------
// adpcm_queue
// Short command queue between the frame front and the sample engine.
// ----------------------------------------------------------------------------
module adpcm_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  adpcm_pkg::frame_cmd_t push_cmd,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output adpcm_pkg::frame_cmd_t pop_cmd
);
    import adpcm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    frame_cmd_t        store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_FULL)
        else $error("command queue holds more entries than its depth");
`endif

endmodule

FILE: src/adpcm_back.sv
// ----------------------------------------------------------------------------
// adpcm_back
// Sample engine: runs the two-tap predictor over one frame command at a time
// and drives the registered sample output.
// ----------------------------------------------------------------------------
module adpcm_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  adpcm_pkg::frame_cmd_t                 pop_cmd,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: pcm_sample[15:0]
    output logic signed [adpcm_pkg::SAMPLE_W-1:0] m_tdata,
    output logic                                  m_tlast
);
    import adpcm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } state_t;

    state_t                      state_reg,  state_next;
    frame_cmd_t                  cmd_reg,    cmd_next;
    logic [NIBBLES_W-1:0]        nib_reg,    nib_next;
    logic [COUNT_W-1:0]          idx_reg,    idx_next;
    logic signed [SAMPLE_W-1:0]  h1_reg,     h1_next;
    logic signed [SAMPLE_W-1:0]  h2_reg,     h2_next;
    logic signed [PROD_W-1:0]    prod1_reg,  prod1_next;
    logic signed [PROD_W-1:0]    prod2_reg,  prod2_next;
    logic signed [ACC_W-1:0]     term_reg,   term_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [SAMPLE_W-1:0]  m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;

    logic                        out_free;
    logic                        produce;
    logic                        last_sample;
    logic signed [ACC_W-1:0]     nib_ext;
    logic signed [ACC_W-1:0]     sum;
    logic signed [ACC_W-1:0]     shifted;
    logic signed [SAMPLE_W-1:0]  sample;

    assign out_free    = !m_valid_reg || m_tready;
    assign pop_ready   = (state_reg == ST_IDLE);
    assign last_sample = (idx_reg == COUNT_W'(cmd_reg.count - 1'b1));
    assign produce     = (state_reg == ST_ACC) && out_free;

    // The current nibble always sits at the top of the shifting nibble word.
    assign nib_ext = $signed({{(ACC_W-4){nib_reg[NIBBLES_W-1]}},
                              nib_reg[NIBBLES_W-1:NIBBLES_W-4]});

    assign sum = term_reg + ROUND_BIAS
               + $signed({{(ACC_W-PROD_W){prod1_reg[PROD_W-1]}}, prod1_reg})
               + $signed({{(ACC_W-PROD_W){prod2_reg[PROD_W-1]}}, prod2_reg});
    assign shifted = sum >>> FRAC_BITS;

    always_comb begin
        if (shifted > ACC_MAX) begin
            sample = SAMPLE_MAX;
        end else if (shifted < ACC_MIN) begin
            sample = SAMPLE_MIN;
        end else begin
            sample = shifted[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        nib_next     = nib_reg;
        idx_next     = idx_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        prod1_next   = prod1_reg;
        prod2_next   = prod2_reg;
        term_next    = term_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = produce || (m_valid_reg && !m_tready);

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    cmd_next = pop_cmd;
                    nib_next = pop_cmd.nibbles;
                    idx_next = '0;
                    if (pop_cmd.restart) begin
                        h1_next = SAMPLE_ZERO;
                        h2_next = SAMPLE_ZERO;
                    end
                    // A frame with nothing to emit only applies its restart.
                    if (pop_cmd.count != COUNT_NONE) begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod1_next = cmd_reg.c1 * h1_reg;
                prod2_next = cmd_reg.c2 * h2_reg;
                term_next  = (nib_ext <<< cmd_reg.shift) <<< FRAC_BITS;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (out_free) begin
                    m_data_next = sample;
                    m_last_next = last_sample;
                    h2_next     = h1_reg;
                    h1_next     = sample;
                    nib_next    = nib_reg << 4;
                    idx_next    = idx_reg + 1'b1;
                    state_next  = last_sample ? ST_IDLE : ST_MUL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            h1_reg      <= SAMPLE_ZERO;
            h2_reg      <= SAMPLE_ZERO;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            h1_reg      <= h1_next;
            h2_reg      <= h2_next;
            cmd_reg     <= cmd_next;
            nib_reg     <= nib_next;
            idx_reg     <= idx_next;
            prod1_reg   <= prod1_next;
            prod2_reg   <= prod2_next;
            term_reg    <= term_next;
            m_data_reg  <= m_data_next;
            m_last_reg  <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_idx_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (idx_reg < cmd_reg.count))
        else $error("sample index ran past the frame's emit count");
    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && last_sample) |=> (state_reg == ST_IDLE && m_tlast))
        else $error("last sample of a frame did not return the engine to idle");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !pop_ready)
        else $error("engine took a new frame while one was in progress");
`endif

endmodule

FILE: src/dsp_adpcm_frame_decoder.sv
// ----------------------------------------------------------------------------
// dsp_adpcm_frame_decoder
// Decodes 4-bit DSP ADPCM frames into saturated 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Usage:
// Load the eight predictor pairs over the cfg channel (index 0..7, c1 in bits
// 31:16, c2 in bits 15:0) while no frame is in flight; other indexes are
// dropped. Each s_ word is one 8-byte frame plus its emit count; s_tuser set
// clears both history samples before that frame is decoded. The m_ channel
// returns one word per sample, with m_tlast on the last sample of a frame.
// Each sample goes through a multiply stage and then an accumulate/saturate
// stage, because the next product needs the sample just produced. The first
// sample of a frame passes the queue and the command and product registers
// before the output register. Up to QUEUE_DEPTH frames wait in the
// command queue while the engine is busy. If the receiver stalls, the engine
// holds its sample in the output register, the queue fills and s_tready drops.
// Reset clears the coefficients, both history samples and the queue.
// ----------------------------------------------------------------------------
module dsp_adpcm_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adpcm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [adpcm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: frame_header[7:0], frame_nibbles[63:8], emit_count[67:64], zero pad
    input  logic [adpcm_pkg::S_TDATA_W-1:0]       s_tdata,
    // s_tuser: restart
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: pcm_sample[15:0]
    output logic signed [adpcm_pkg::SAMPLE_W-1:0] m_tdata,
    // m_tlast: last_of_frame
    output logic                                  m_tlast
);
    import adpcm_pkg::*;

    frame_cmd_t push_cmd;
    frame_cmd_t pop_cmd;
    logic       push_valid, push_ready;
    logic       pop_valid,  pop_ready;

    adpcm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd       (push_cmd)
    );

    adpcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    adpcm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
